[rtl/core/rchm_pkg.sv]
// Shared types, codes and default sizes of the refcounted chained hash map.
package rchm_pkg;

  // Default sizes
  localparam int unsigned BucketsDef = 256;
  localparam int unsigned EntriesDef = 1024;
  localparam int unsigned RefBitsDef = 16;

  // Request kinds; codes five to seven behave as a plain lookup
  typedef enum logic [2:0] {
    KIND_INSERT  = 3'd0,
    KIND_LOOKUP  = 3'd1,
    KIND_ADDREF  = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_REMOVE  = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_EXEC,
    S_POP,
    S_LINK,
    S_FIXPREV
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key_hash;
    logic [31:0] key;
    logic [31:0] data;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] data_out;
    status_e     status;
    logic [15:0] refs_after;
    logic [10:0] entries_used;
  } rsp_t;

endpackage

[rtl/core/refcounted_chained_hash_map.sv]
// Top level: hash map with chained buckets and reference counted entries.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  request   | start, busy            | req_i : kind, key_hash, key, data
//  result    | done_o (1-cycle pulse) | rsp_o : found, data_out, status,
//            |                        |         refs_after, entries_used
//
// A request reads its bucket head, walks the bucket chain to decide, then may
// write back (free list pop, link, predecessor fix); the result is registered
// and appears in the cycle after the last step. The walk is set by the
// single read port of the entry memory: one chain entry per cycle.
// After reset all 2**ceil(log2(BUCKETS)) bucket heads are cleared, one head
// per cycle; busy is high meanwhile.
// The receiver cannot stall: each result is valid exactly while done_o is high.
module refcounted_chained_hash_map #(
  parameter int unsigned BUCKETS  = rchm_pkg::BucketsDef,
  parameter int unsigned ENTRIES  = rchm_pkg::EntriesDef,
  parameter int unsigned REF_BITS = rchm_pkg::RefBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rchm_pkg::req_t req_i,
  output logic           done_o,
  output rchm_pkg::rsp_t rsp_o
);

  localparam int unsigned BktW  = $clog2(BUCKETS);
  localparam int unsigned HaW   = (BktW > 0) ? BktW : 1;
  localparam int unsigned BktN  = 1 << BktW;
  localparam int unsigned LnkW  = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [LnkW-1:0] Nil = LnkW'(ENTRIES);
  localparam logic [HaW-1:0]  LastBkt = HaW'(BktN - 1);

  typedef struct packed {
    logic [31:0]         hash;
    logic [31:0]         key;
    logic [31:0]         data;
    logic [REF_BITS-1:0] refs;
    logic [LnkW-1:0]     nxt;
  } ent_t;

  // Memories
  logic [LnkW-1:0] head_mem [BktN];
  ent_t            ent_mem  [ENTRIES];

  logic            hd_we;
  logic [HaW-1:0]  hd_waddr, hd_raddr;
  logic [LnkW-1:0] hd_wdata, hd_rdata_q;
  logic            en_we;
  logic [IdxW-1:0] en_waddr, en_raddr;
  ent_t            en_wdata, en_rdata_q;

  // State
  rchm_pkg::state_e state_q, state_d;
  rchm_pkg::req_t   req_q;
  logic [HaW-1:0]   clr_q, clr_d;
  logic [LnkW-1:0]  cur_q, cur_d, prev_q, prev_d, idx_q, idx_d, nlink_q, nlink_d;
  logic [LnkW-1:0]  free_hd_q, free_hd_d, fresh_q, fresh_d, used_q, used_d;
  ent_t             cur_w_q, cur_w_d, prev_w_q, prev_w_d;
  logic             hit_q, hit_d;
  rchm_pkg::rsp_t   pend_q, pend_d, rsp_q, rsp_d;
  logic             done_q, done_d;

  // Result assembly
  logic                 fin, go_fix, fin_found;
  logic [31:0]          fin_data;
  rchm_pkg::status_e    fin_status;
  logic [REF_BITS-1:0]  fin_refs;
  logic [31:0]          refs32, used32;
  rchm_pkg::rsp_t       fin_rsp;

  logic [HaW-1:0] req_bkt, q_bkt;
  logic           accept, match, is_ins;

  assign busy   = (state_q != rchm_pkg::S_IDLE);
  assign accept = start && !busy;
  assign req_bkt = (BktW == 0) ? '0 : req_i.key_hash[HaW-1:0];
  assign q_bkt   = (BktW == 0) ? '0 : req_q.key_hash[HaW-1:0];
  assign match   = (en_rdata_q.hash == req_q.key_hash) && (en_rdata_q.key == req_q.key);
  assign is_ins  = (req_q.kind == rchm_pkg::KIND_INSERT);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rchm_pkg::S_CLEAR: begin
        if (clr_q == LastBkt) state_d = rchm_pkg::S_IDLE;
      end
      rchm_pkg::S_IDLE: begin
        if (accept) state_d = rchm_pkg::S_HEAD;
      end
      rchm_pkg::S_HEAD: begin
        state_d = (hd_rdata_q == Nil) ? rchm_pkg::S_EXEC : rchm_pkg::S_WALK;
      end
      rchm_pkg::S_WALK: begin
        if (match || en_rdata_q.nxt == Nil) state_d = rchm_pkg::S_EXEC;
      end
      rchm_pkg::S_EXEC: begin
        if (is_ins && !hit_q && used_q != Nil) begin
          state_d = (free_hd_q != Nil) ? rchm_pkg::S_POP : rchm_pkg::S_LINK;
        end else if (go_fix) begin
          state_d = rchm_pkg::S_FIXPREV;
        end else begin
          state_d = rchm_pkg::S_IDLE;
        end
      end
      rchm_pkg::S_POP: state_d = rchm_pkg::S_LINK;
      rchm_pkg::S_LINK: begin
        state_d = go_fix ? rchm_pkg::S_FIXPREV : rchm_pkg::S_IDLE;
      end
      rchm_pkg::S_FIXPREV: state_d = rchm_pkg::S_IDLE;
      default: state_d = rchm_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_d     = clr_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    idx_d     = idx_q;
    nlink_d   = nlink_q;
    free_hd_d = free_hd_q;
    fresh_d   = fresh_q;
    used_d    = used_q;
    cur_w_d   = cur_w_q;
    prev_w_d  = prev_w_q;
    hit_d     = hit_q;
    pend_d    = pend_q;
    hd_we     = 1'b0;
    hd_waddr  = q_bkt;
    hd_wdata  = Nil;
    hd_raddr  = req_bkt;
    en_we     = 1'b0;
    en_waddr  = cur_q[IdxW-1:0];
    en_wdata  = cur_w_q;
    en_raddr  = cur_q[IdxW-1:0];
    fin       = 1'b0;
    go_fix    = 1'b0;
    fin_found = 1'b0;
    fin_data  = '0;
    fin_status = rchm_pkg::ST_DONE;
    fin_refs  = '0;
    unique case (state_q)
      rchm_pkg::S_CLEAR: begin
        // sweep every bucket head to empty
        hd_we    = 1'b1;
        hd_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
      end
      rchm_pkg::S_IDLE: begin
        prev_d = Nil;
        hit_d  = 1'b0;
      end
      rchm_pkg::S_HEAD: begin
        cur_d    = hd_rdata_q;
        en_raddr = hd_rdata_q[IdxW-1:0];
      end
      rchm_pkg::S_WALK: begin
        // compare, then advance along the chain
        if (match) begin
          hit_d   = 1'b1;
          cur_w_d = en_rdata_q;
        end else begin
          prev_d   = cur_q;
          prev_w_d = en_rdata_q;
          cur_d    = en_rdata_q.nxt;
          en_raddr = en_rdata_q.nxt[IdxW-1:0];
        end
      end
      rchm_pkg::S_EXEC: begin
        if (is_ins) begin
          if (hit_q) begin
            fin = 1'b1; fin_found = 1'b1; fin_data = cur_w_q.data;
            fin_status = rchm_pkg::ST_DUP; fin_refs = cur_w_q.refs;
          end else if (used_q == Nil) begin
            fin = 1'b1; fin_status = rchm_pkg::ST_FULL;
          end else if (free_hd_q != Nil) begin
            idx_d    = free_hd_q;
            en_raddr = free_hd_q[IdxW-1:0];
          end else begin
            idx_d   = fresh_q;
            fresh_d = fresh_q + 1'b1;
          end
        end else if (!hit_q) begin
          fin = 1'b1; fin_status = rchm_pkg::ST_NOTFOUND;
        end else if (req_q.kind == rchm_pkg::KIND_RELEASE && cur_w_q.refs > REF_BITS'(1)) begin
          // drop one reference
          en_we         = 1'b1;
          en_wdata.refs = cur_w_q.refs - 1'b1;
          fin = 1'b1; fin_found = 1'b1; fin_data = cur_w_q.data;
          fin_refs = cur_w_q.refs - 1'b1;
        end else if (req_q.kind == rchm_pkg::KIND_RELEASE ||
                     req_q.kind == rchm_pkg::KIND_REMOVE) begin
          // unlink and push onto the free list
          en_we         = 1'b1;
          en_wdata.refs = '0;
          en_wdata.nxt  = free_hd_q;
          free_hd_d     = cur_q;
          used_d        = used_q - 1'b1;
          fin_found = 1'b1; fin_data = cur_w_q.data;
          fin_status = rchm_pkg::ST_REMOVED;
          if (prev_q == Nil) begin
            hd_we = 1'b1; hd_wdata = cur_w_q.nxt; fin = 1'b1;
          end else begin
            go_fix = 1'b1; nlink_d = cur_w_q.nxt;
          end
        end else if (req_q.kind == rchm_pkg::KIND_ADDREF) begin
          en_we = 1'b1;
          en_wdata.refs = (&cur_w_q.refs) ? cur_w_q.refs : cur_w_q.refs + 1'b1;
          fin = 1'b1; fin_found = 1'b1; fin_data = cur_w_q.data;
          fin_refs = en_wdata.refs;
        end else begin
          fin = 1'b1; fin_found = 1'b1; fin_data = cur_w_q.data;
          fin_refs = cur_w_q.refs;
        end
      end
      rchm_pkg::S_POP: begin
        free_hd_d = en_rdata_q.nxt;
      end
      rchm_pkg::S_LINK: begin
        // write the new entry at the chain tail
        en_we    = 1'b1;
        en_waddr = idx_q[IdxW-1:0];
        en_wdata = '{hash: req_q.key_hash, key: req_q.key, data: req_q.data,
                     refs: REF_BITS'(1), nxt: Nil};
        used_d   = used_q + 1'b1;
        fin_refs = REF_BITS'(1);
        if (prev_q == Nil) begin
          hd_we = 1'b1; hd_wdata = idx_q; fin = 1'b1;
        end else begin
          go_fix = 1'b1; nlink_d = idx_q;
        end
      end
      rchm_pkg::S_FIXPREV: begin
        en_we        = 1'b1;
        en_waddr     = prev_q[IdxW-1:0];
        en_wdata     = prev_w_q;
        en_wdata.nxt = nlink_q;
      end
      default: ;
    endcase
    if (go_fix) pend_d = fin_rsp;
  end

  assign refs32 = 32'(fin_refs);
  assign used32 = 32'(used_d);
  always_comb begin
    fin_rsp.found        = fin_found;
    fin_rsp.data_out     = fin_data;
    fin_rsp.status       = fin_status;
    fin_rsp.refs_after   = refs32[15:0];
    fin_rsp.entries_used = used32[10:0];
  end

  // Result strobe
  always_comb begin
    done_d = fin || (state_q == rchm_pkg::S_FIXPREV);
    rsp_d  = (state_q == rchm_pkg::S_FIXPREV) ? pend_q : fin_rsp;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_waddr] <= hd_wdata;
    hd_rdata_q <= head_mem[hd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (en_we) ent_mem[en_waddr] <= en_wdata;
    en_rdata_q <= ent_mem[en_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rchm_pkg::S_CLEAR;
      clr_q     <= '0;
      free_hd_q <= Nil;
      fresh_q   <= '0;
      used_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      free_hd_q <= free_hd_d;
      fresh_q   <= fresh_d;
      used_q    <= used_d;
      done_q    <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    idx_q    <= idx_d;
    nlink_q  <= nlink_d;
    cur_w_q  <= cur_w_d;
    prev_w_q <= prev_w_d;
    hit_q    <= hit_d;
    pend_q   <= pend_d;
    rsp_q    <= rsp_d;
  end

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("back-to-back result strobes");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == rchm_pkg::S_IDLE)) else $error("result while busy");
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Nil) else $error("entry count out of range");
  a_head_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hd_we |-> (hd_wdata <= Nil)) else $error("bad bucket head link");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted request did not raise busy");
`endif

endmodule

[verif/tb_refcounted_chained_hash_map.sv]
// Testbench of the refcounted chained hash map: random and directed requests against a predictor.
module tb_refcounted_chained_hash_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBUCK = 256;
  localparam int unsigned NENT = 1024;
  localparam logic [15:0] REF_SAT = 16'hFFFF;
  localparam int unsigned WATCHDOG_CYCLES = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rchm_pkg::req_t req_i = '0;
  logic done_o;
  rchm_pkg::rsp_t rsp_o;

  refcounted_chained_hash_map dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Map shadow: chains of entry indexes per bucket, pool arrays, free stack
  int          chain_q[NBUCK][$];
  logic [31:0] ent_key[NENT];
  logic [31:0] ent_hash[NENT];
  logic [31:0] ent_data[NENT];
  logic [15:0] ent_refs[NENT];
  int          free_idx[$];
  int          used_cnt;

  rchm_pkg::req_t pending_q[$];
  rchm_pkg::rsp_t expected_rsp_q[$];
  int   mismatches = 0;
  bit   no_idle = 0;
  bit   hold_send = 0;
  int   stall_cycles = 0;

  // Compute the response of one request and update the shadow map
  function automatic rchm_pkg::rsp_t apply_request(rchm_pkg::req_t r);
    rchm_pkg::rsp_t o;
    int b, pos, e;
    b = r.key_hash[7:0];
    pos = -1;
    o = '0;
    for (int i = 0; i < chain_q[b].size(); i++) begin
      if (pos < 0 && ent_hash[chain_q[b][i]] == r.key_hash && ent_key[chain_q[b][i]] == r.key)
        pos = i;
    end
    if (r.kind == rchm_pkg::KIND_INSERT) begin
      if (pos >= 0) begin
        e = chain_q[b][pos];
        o.found = 1'b1; o.data_out = ent_data[e]; o.status = rchm_pkg::ST_DUP;
        o.refs_after = ent_refs[e];
      end else if (free_idx.size() == 0) begin
        o.status = rchm_pkg::ST_FULL;
      end else begin
        e = free_idx.pop_back();
        ent_key[e] = r.key; ent_hash[e] = r.key_hash; ent_data[e] = r.data;
        ent_refs[e] = 16'd1;
        chain_q[b].push_back(e);
        used_cnt++;
        o.status = rchm_pkg::ST_DONE; o.refs_after = 16'd1;
      end
    end else if (pos < 0) begin
      o.status = rchm_pkg::ST_NOTFOUND;
    end else begin
      e = chain_q[b][pos];
      o.found = 1'b1;
      o.data_out = ent_data[e];
      o.status = rchm_pkg::ST_DONE;
      if (r.kind == rchm_pkg::KIND_ADDREF) begin
        if (ent_refs[e] < REF_SAT) ent_refs[e]++;
        o.refs_after = ent_refs[e];
      end else if (r.kind == rchm_pkg::KIND_RELEASE && ent_refs[e] > 16'd1) begin
        ent_refs[e]--;
        o.refs_after = ent_refs[e];
      end else if (r.kind == rchm_pkg::KIND_RELEASE || r.kind == rchm_pkg::KIND_REMOVE) begin
        chain_q[b].delete(pos);
        ent_refs[e] = 16'd0;
        free_idx.push_back(e);
        used_cnt--;
        o.status = rchm_pkg::ST_REMOVED;
      end else begin
        o.refs_after = ent_refs[e];
      end
    end
    o.entries_used = used_cnt[10:0];
    return o;
  endfunction

  function automatic rchm_pkg::req_t make_req(logic [2:0] k, logic [31:0] h, logic [31:0] ky,
                                              logic [31:0] d);
    rchm_pkg::req_t r;
    r.kind = k; r.key_hash = h; r.key = ky; r.data = d;
    return r;
  endfunction

  // Driver: present the oldest pending request, hold it until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsp_q.push_back(apply_request(req_i));
        void'(pending_q.pop_front());
      end
      if (pending_q.size() > 0 && !hold_send && (no_idle || $urandom_range(99) >= 16)) begin
        start <= 1'b1;
        req_i <= pending_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed response with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp_o);
      end else begin
        rchm_pkg::rsp_t x;
        x = expected_rsp_q.pop_front();
        if (rsp_o !== x) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", x, rsp_o);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_CYCLES) begin
      $display("tb_refcounted_chained_hash_map: FAIL");
      $finish;
    end
  end

  // Pick a key from a small pool so hits, collisions and chains are common
  function automatic rchm_pkg::req_t rand_req(int nkeys);
    logic [31:0] ky, h;
    logic [2:0] k;
    int p;
    ky = $urandom_range(nkeys - 1);
    h = {ky[31:4] ^ 28'h5a5a5a5, ky[3:0]};
    if ($urandom_range(9) == 0) h[31:8] = 24'($urandom);
    p = $urandom_range(99);
    if (p < 35) k = rchm_pkg::KIND_INSERT;
    else if (p < 50) k = rchm_pkg::KIND_LOOKUP;
    else if (p < 68) k = rchm_pkg::KIND_ADDREF;
    else if (p < 85) k = rchm_pkg::KIND_RELEASE;
    else if (p < 95) k = rchm_pkg::KIND_REMOVE;
    else k = 3'($urandom_range(7, 5));
    return make_req(k, h, ky, $urandom);
  endfunction

  initial begin
    int n;
    for (int i = 0; i < NENT; i++) free_idx.push_back(i);
    used_cnt = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every kind, duplicate, missing key, collisions
    pending_q.push_back(make_req(rchm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF));
    pending_q.push_back(make_req(rchm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234));
    pending_q.push_back(make_req(rchm_pkg::KIND_INSERT, 32'h0, 32'h0, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_INSERT, 32'h100, 32'h0, 32'hA5A5_A5A5));
    pending_q.push_back(make_req(rchm_pkg::KIND_INSERT, 32'h0, 32'h1, 32'h5A5A_5A5A));
    pending_q.push_back(make_req(rchm_pkg::KIND_LOOKUP, 32'h100, 32'h0, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_ADDREF, 32'h0, 32'h1, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_RELEASE, 32'h0, 32'h1, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_RELEASE, 32'h0, 32'h1, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_RELEASE, 32'h0, 32'h1, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_REMOVE, 32'h0, 32'h0, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_LOOKUP, 32'h100, 32'h0, 32'h0));
    pending_q.push_back(make_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    pending_q.push_back(make_req(3'd6, 32'h1, 32'h1, 32'h0));
    pending_q.push_back(make_req(3'd7, 32'h100, 32'h0, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_REMOVE, 32'h7, 32'h7, 32'h0));
    // Raise one count with an add reference burst
    for (int i = 0; i < 40; i++)
      pending_q.push_back(make_req(rchm_pkg::KIND_ADDREF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    pending_q.push_back(make_req(rchm_pkg::KIND_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    no_idle = 1;
    wait (pending_q.size() == 0);
    no_idle = 0;

    // Random traffic over a small key space
    for (n = 0; n < 350; n++) pending_q.push_back(rand_req(n < 175 ? 64 : 600));
    wait (pending_q.size() == 0);
    hold_send = 1;
    wait (expected_rsp_q.size() == 0);
    hold_send = 0;

    // Fill the pool to the full flag, probe it, then drain part of it
    for (int i = 0; i < NENT + 4; i++)
      pending_q.push_back(make_req(rchm_pkg::KIND_INSERT, $urandom, $urandom, $urandom));
    for (n = 0; n < 420; n++) pending_q.push_back(rand_req(n < 280 ? 2048 : 128));
    wait (pending_q.size() == 0);
    wait (expected_rsp_q.size() == 0);
    repeat (NENT + 20) @(posedge clk_i);
    if (mismatches == 0 && expected_rsp_q.size() == 0)
      $display("tb_refcounted_chained_hash_map: PASS");
    else
      $display("tb_refcounted_chained_hash_map: FAIL");
    $finish;
  end
endmodule
